FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// No dependencies; simulation builds get the checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/nca_pkg.sv
// Package for the nearest-centroid assignment unit: field widths, codes, defaults.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package nca_pkg;

   localparam int FIELD_COORDS     = 8;   // coordinate fields per beat
   localparam int COORD_FIELD_BITS = 16;
   localparam int IDX_BITS         = 3;
   localparam int SLOT_COUNT       = 2 ** IDX_BITS;
   localparam int DIST_FIELD_BITS  = 19;
   localparam int CNT_BITS         = 4;
   localparam int CSR_IDX_BITS     = 8;
   localparam int CSR_DATA_BITS    = 16;

   localparam int DEF_MAX_CLUSTERS = 8;
   localparam int DEF_MAX_DIMS     = 8;
   localparam int DEF_COORD_BITS   = 16;

   localparam logic [CNT_BITS-1:0] CLUSTERS_RESET = 4'd5;
   localparam logic [CNT_BITS-1:0] DIMS_RESET     = 4'd8;

   typedef enum logic {
      ACT_LOAD     = 1'b0,
      ACT_CLASSIFY = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CLUSTERS = 8'd0,
      CSR_DIMS     = 8'd1
   } csr_index_type;

   // zero acts as one, anything above the limit saturates
   function automatic logic [CNT_BITS-1:0] clamp_count(
      input logic [CNT_BITS-1:0] v,
      input logic [CNT_BITS-1:0] limit
   );
      logic [CNT_BITS-1:0] r;
      if (v == '0) begin
         r = CNT_BITS'(1);
      end else if (v > limit) begin
         r = limit;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/nca_channels.sv
// Channel interfaces of the nearest-centroid assignment unit: request, response, CSR write.
// Depends on nca_pkg for the field widths.
`timescale 1ns / 1ps

interface nca_req_if;
   import nca_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [IDX_BITS-1:0]         cluster_index;
   logic [COORD_FIELD_BITS-1:0] coord0;
   logic [COORD_FIELD_BITS-1:0] coord1;
   logic [COORD_FIELD_BITS-1:0] coord2;
   logic [COORD_FIELD_BITS-1:0] coord3;
   logic [COORD_FIELD_BITS-1:0] coord4;
   logic [COORD_FIELD_BITS-1:0] coord5;
   logic [COORD_FIELD_BITS-1:0] coord6;
   logic [COORD_FIELD_BITS-1:0] coord7;

   modport source (output valid, action, cluster_index, coord0, coord1, coord2, coord3,
                   coord4, coord5, coord6, coord7, input ready);
   modport sink   (input valid, action, cluster_index, coord0, coord1, coord2, coord3,
                   coord4, coord5, coord6, coord7, output ready);
endinterface

interface nca_rsp_if;
   import nca_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [IDX_BITS-1:0]        best_cluster;
   logic [DIST_FIELD_BITS-1:0] best_distance;

   modport source (output valid, best_cluster, best_distance, input ready);
   modport sink   (input valid, best_cluster, best_distance, output ready);
endinterface

interface nca_csr_if;
   import nca_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  reg_index;
   logic [CSR_DATA_BITS-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/core/nearest_centroid_assign_unit.sv
// Nearest-centroid (k-means assignment, Manhattan) unit, eight register stages.
// A classify beat passes through stages 1 to 8; rsp valid is the stage 8 valid register.
// One beat per cycle unless stalled; a load beat retires in stage 1, writing its row there.
// Stalls back up stage by stage from the response register; bubbles close up.
// Reset: centroid rows cleared to zero, clusters_in_use 5, dims_in_use 8, pipe empty.
// Depends on nca_pkg, nca_channels and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nearest_centroid_assign_unit #(
   parameter int MAX_CLUSTERS = nca_pkg::DEF_MAX_CLUSTERS,
   parameter int MAX_DIMS     = nca_pkg::DEF_MAX_DIMS,
   parameter int COORD_BITS   = nca_pkg::DEF_COORD_BITS
) (
   input logic       clock,
   input logic       reset,
   nca_req_if.sink   req_bus,
   nca_rsp_if.source rsp_bus,
   nca_csr_if.sink   csr_bus
);
   import nca_pkg::*;

   localparam int NROWS = (MAX_CLUSTERS < SLOT_COUNT) ? MAX_CLUSTERS : SLOT_COUNT;
   localparam int NCOLS = (MAX_DIMS < FIELD_COORDS) ? MAX_DIMS : FIELD_COORDS;
   localparam int CW    = (COORD_BITS < COORD_FIELD_BITS) ? COORD_BITS : COORD_FIELD_BITS;
   localparam int DW    = CW + 3;
   localparam int NSTG  = 8;

   typedef logic [CW-1:0] coord_type;

   typedef struct packed {
      logic                ok;
      logic [IDX_BITS-1:0] idx;
      logic [DW-1:0]       total;
   } cand_type;

   // later cluster wins on equal distance
   function automatic cand_type pick(input cand_type lo, input cand_type hi);
      cand_type r;
      if (hi.ok && (!lo.ok || hi.total <= lo.total)) begin
         r = hi;
      end else begin
         r = lo;
      end
      return r;
   endfunction

   // ---------------- configuration ----------------
   logic [CNT_BITS-1:0] clusters_ff;
   logic [CNT_BITS-1:0] dims_ff;
   logic [CNT_BITS-1:0] nc_eff;
   logic [CNT_BITS-1:0] nd_eff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clusters_ff <= CLUSTERS_RESET;
         dims_ff     <= DIMS_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_CLUSTERS: clusters_ff <= csr_bus.wdata[CNT_BITS-1:0];
            CSR_DIMS:     dims_ff     <= csr_bus.wdata[CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign nc_eff = clamp_count(clusters_ff, CNT_BITS'(NROWS));
   assign nd_eff = clamp_count(dims_ff, CNT_BITS'(NCOLS));

   // ---------------- stage control ----------------
   logic [NSTG:1]   v_ff;
   logic [NSTG:1]   v_in;
   logic [NSTG+1:1] rdy;

   always_comb begin
      rdy[NSTG+1] = rsp_bus.ready;
      for (int k = NSTG; k >= 1; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   // ---------------- stage 1: input register ----------------
   logic                act1_ff;
   logic [IDX_BITS-1:0] row1_ff;
   coord_type           pt1_ff [FIELD_COORDS];
   coord_type           pt1_in [FIELD_COORDS];

   assign pt1_in[0] = req_bus.coord0[CW-1:0];
   assign pt1_in[1] = req_bus.coord1[CW-1:0];
   assign pt1_in[2] = req_bus.coord2[CW-1:0];
   assign pt1_in[3] = req_bus.coord3[CW-1:0];
   assign pt1_in[4] = req_bus.coord4[CW-1:0];
   assign pt1_in[5] = req_bus.coord5[CW-1:0];
   assign pt1_in[6] = req_bus.coord6[CW-1:0];
   assign pt1_in[7] = req_bus.coord7[CW-1:0];

   assign req_bus.ready = rdy[1];

   always_comb begin
      v_in[1] = req_bus.valid;
      v_in[2] = v_ff[1] && (act1_ff == ACT_CLASSIFY);
      for (int k = 3; k <= NSTG; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= NSTG; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         act1_ff <= req_bus.action;
         row1_ff <= req_bus.cluster_index;
         for (int j = 0; j < FIELD_COORDS; j++) begin
            pt1_ff[j] <= pt1_in[j];
         end
      end
   end

   // ---------------- centroid rows ----------------
   // written as the load leaves stage 1, the same place classify beats read them
   coord_type store_ff [NROWS][NCOLS];
   logic      load_fire;

   assign load_fire = v_ff[1] && (act1_ff == ACT_LOAD) && rdy[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NROWS; r++) begin
            for (int j = 0; j < NCOLS; j++) begin
               store_ff[r][j] <= '0;
            end
         end
      end else if (load_fire) begin
         for (int r = 0; r < NROWS; r++) begin
            if (row1_ff == IDX_BITS'(r)) begin
               for (int j = 0; j < NCOLS; j++) begin
                  store_ff[r][j] <= pt1_ff[j];
               end
            end
         end
      end
   end

   // ---------------- stage 2: absolute differences ----------------
   coord_type diff2_ff [SLOT_COUNT][FIELD_COORDS];
   coord_type diff2_in [SLOT_COUNT][FIELD_COORDS];

   for (genvar c = 0; c < SLOT_COUNT; c++) begin : g_row
      for (genvar j = 0; j < FIELD_COORDS; j++) begin : g_col
         if (c < NROWS && j < NCOLS) begin : g_live
            always_comb begin
               if (CNT_BITS'(j) >= nd_eff) begin
                  diff2_in[c][j] = '0;
               end else if (pt1_ff[j] >= store_ff[c][j]) begin
                  diff2_in[c][j] = pt1_ff[j] - store_ff[c][j];
               end else begin
                  diff2_in[c][j] = store_ff[c][j] - pt1_ff[j];
               end
            end
         end else begin : g_pad
            assign diff2_in[c][j] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         diff2_ff <= diff2_in;
      end
   end

   // ---------------- stages 3 to 5: adder tree per cluster ----------------
   logic [CW:0]   sum3_ff [SLOT_COUNT][4];
   logic [CW+1:0] sum4_ff [SLOT_COUNT][2];
   cand_type      cand5_ff [SLOT_COUNT];

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         for (int c = 0; c < SLOT_COUNT; c++) begin
            for (int p = 0; p < 4; p++) begin
               sum3_ff[c][p] <= {1'b0, diff2_ff[c][2*p]} + {1'b0, diff2_ff[c][2*p+1]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         for (int c = 0; c < SLOT_COUNT; c++) begin
            for (int p = 0; p < 2; p++) begin
               sum4_ff[c][p] <= {1'b0, sum3_ff[c][2*p]} + {1'b0, sum3_ff[c][2*p+1]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         for (int c = 0; c < SLOT_COUNT; c++) begin
            cand5_ff[c].ok    <= CNT_BITS'(c) < nc_eff;
            cand5_ff[c].idx   <= IDX_BITS'(c);
            cand5_ff[c].total <= {1'b0, sum4_ff[c][0]} + {1'b0, sum4_ff[c][1]};
         end
      end
   end

   // ---------------- stages 6 to 8: compare tree ----------------
   cand_type cand6_ff [4];
   cand_type cand7_ff [2];
   cand_type cand8_ff;

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         for (int p = 0; p < 4; p++) begin
            cand6_ff[p] <= pick(cand5_ff[2*p], cand5_ff[2*p+1]);
         end
      end
      if (rdy[7]) begin
         for (int p = 0; p < 2; p++) begin
            cand7_ff[p] <= pick(cand6_ff[2*p], cand6_ff[2*p+1]);
         end
      end
      if (rdy[8]) begin
         cand8_ff <= pick(cand7_ff[0], cand7_ff[1]);
      end
   end

   assign rsp_bus.valid         = v_ff[NSTG];
   assign rsp_bus.best_cluster  = cand8_ff.idx;
   assign rsp_bus.best_distance = DIST_FIELD_BITS'(cand8_ff.total);

   // ---------------- checks ----------------
   `ASSERT_NXT(a_reset_empties_pipe, clock, 1'b0, reset, v_ff == '0)
   `ASSERT_NXT(a_load_gives_no_beat, clock, reset, load_fire, !v_ff[2])
   `ASSERT_IMP(a_winner_in_use, clock, reset, v_ff[NSTG], cand8_ff.ok)

endmodule
